// ===== design/round_robin_thread_scheduler_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the thread scheduler core
// Shared concurrent assertion forms, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define RRTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rrts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Types and codes shared by the thread scheduler modules.
// ----------------------------------------------------------------------------
package rrts_pkg;

   localparam int unsigned THREAD_SLOTS_DEF = 16;

   localparam int unsigned ADDR_W   = 32;
   localparam int unsigned ID_OUT_W = 4;
   localparam int unsigned STAT_W   = 2;

   // request opcodes
   localparam logic OPC_SPAWN = 1'b0;
   localparam logic OPC_YIELD = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] RSP_OK        = 2'd0;
   localparam logic [STAT_W-1:0] RSP_REFUSED   = 2'd1;
   localparam logic [STAT_W-1:0] RSP_NO_SWITCH = 2'd2;

   typedef enum logic [1:0] {
      TS_ZOMBIE  = 2'd0,
      TS_READY   = 2'd1,
      TS_RUNNING = 2'd2
   } thread_state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPAWN,
      ST_SEEK
   } fsm_state_type;

   // commands broadcast from the controller to every cell
   typedef struct packed {
      logic spawn;       // write the cell addressed by the spawn id
      logic seek_start;  // place the search token
      logic seek_step;   // move the token one cell on
      logic commit;      // token cell runs, running cell becomes ready
   } cell_cmd_type;

endpackage

// ===== design/rrts_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_cell
// One thread slot: status, start address and the search token stage.
// ----------------------------------------------------------------------------
module rrts_cell
   import rrts_pkg::*;
#(
   parameter int unsigned THREAD_SLOTS = THREAD_SLOTS_DEF,
   parameter int unsigned CELL_INDEX   = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cell_cmd_type                cmd,
   input  logic [$clog2(THREAD_SLOTS)-1:0] spawn_id,
   input  logic [$clog2(THREAD_SLOTS)-1:0] start_id,
   input  logic [$clog2(THREAD_SLOTS)-1:0] last_id,
   input  logic [ADDR_W-1:0]           spawn_addr,
   input  logic                        token_prev,
   output logic                        token_next,
   output logic                        token_wrap,
   output logic                        hit,
   output logic                        running,
   output logic [ADDR_W-1:0]           entry_addr
);

   localparam int unsigned ID_W = $clog2(THREAD_SLOTS);
   localparam logic [ID_W-1:0] MY_ID = ID_W'(CELL_INDEX);

   thread_state_type  status_ff, status_in;
   logic              token_ff, token_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              is_last;

   assign is_last = (last_id == MY_ID);

   always_comb begin
      status_in = status_ff;
      token_in  = token_ff;
      addr_in   = addr_ff;
      if (cmd.spawn && spawn_id == MY_ID) begin
         status_in = TS_READY;
         addr_in   = spawn_addr;
      end
      if (cmd.seek_start) begin
         token_in = (start_id == MY_ID);
      end else if (cmd.seek_step) begin
         token_in = token_prev;
      end
      if (cmd.commit) begin
         if (token_ff && status_ff == TS_READY) begin
            status_in = TS_RUNNING;
         end else if (status_ff == TS_RUNNING) begin
            status_in = TS_READY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= (CELL_INDEX == 0) ? TS_RUNNING : TS_ZOMBIE;
         token_ff  <= 1'b0;
      end else begin
         status_ff <= status_in;
         token_ff  <= token_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign token_next = token_ff & ~is_last;
   assign token_wrap = token_ff & is_last;
   assign hit        = token_ff && (status_ff == TS_READY);
   assign running    = (status_ff == TS_RUNNING);
   assign entry_addr = addr_ff;

endmodule

// ===== design/rrts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_ctrl
// Request sequencer: thread count, running id, search control, result register.
// ----------------------------------------------------------------------------
module rrts_ctrl
   import rrts_pkg::*;
#(
   parameter int unsigned THREAD_SLOTS = THREAD_SLOTS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic [ADDR_W-1:0]               req_start_address,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [STAT_W-1:0]               rsp_status,
   output logic [ID_OUT_W-1:0]             rsp_thread_id,
   output logic                            rsp_switched,
   output logic [ADDR_W-1:0]               rsp_next_address,
   output cell_cmd_type                    cmd,
   output logic [$clog2(THREAD_SLOTS)-1:0] spawn_id,
   output logic [$clog2(THREAD_SLOTS)-1:0] start_id,
   output logic [$clog2(THREAD_SLOTS)-1:0] last_id,
   output logic [ADDR_W-1:0]               spawn_addr,
   input  logic                            any_hit,
   input  logic [$clog2(THREAD_SLOTS)-1:0] hit_id,
   input  logic [ADDR_W-1:0]               hit_addr
);

   localparam int unsigned ID_W  = $clog2(THREAD_SLOTS);
   localparam int unsigned CNT_W = $clog2(THREAD_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(THREAD_SLOTS);

   fsm_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [ID_W-1:0]     running_ff, running_in;
   logic [CNT_W-1:0]    steps_ff, steps_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ID_OUT_W-1:0] rsp_id_ff, rsp_id_in;
   logic                rsp_switched_ff, rsp_switched_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic                out_free;
   logic                load_out;
   logic [CNT_W-1:0]    run_inc;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign run_inc  = CNT_W'(running_ff) + CNT_W'(1);
   assign start_id = (run_inc == total_ff) ? '0 : ID_W'(run_inc);
   assign last_id  = ID_W'(total_ff - CNT_W'(1));
   assign spawn_id = ID_W'(total_ff);
   assign spawn_addr = addr_ff;

   always_comb begin
      state_in        = state_ff;
      total_in        = total_ff;
      running_in      = running_ff;
      steps_in        = steps_ff;
      addr_in         = addr_ff;
      cmd             = '0;
      req_ready       = 1'b0;
      load_out        = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_switched_in = rsp_switched_ff;
      rsp_addr_in     = rsp_addr_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               addr_in = req_start_address;
               if (req_opcode == OPC_SPAWN) begin
                  state_in = ST_SPAWN;
               end else begin
                  cmd.seek_start = 1'b1;
                  steps_in       = total_ff - CNT_W'(1);
                  state_in       = ST_SEEK;
               end
            end
         end
         ST_SPAWN: begin
            if (out_free) begin
               load_out        = 1'b1;
               rsp_switched_in = 1'b0;
               rsp_addr_in     = '0;
               state_in        = ST_IDLE;
               if (total_ff == SLOTS_CNT || addr_ff == '0) begin
                  rsp_status_in = RSP_REFUSED;
                  rsp_id_in     = '0;
               end else begin
                  cmd.spawn     = 1'b1;
                  total_in      = total_ff + CNT_W'(1);
                  rsp_status_in = RSP_OK;
                  rsp_id_in     = ID_OUT_W'(total_ff);
               end
            end
         end
         ST_SEEK: begin
            if (out_free) begin
               if (any_hit) begin
                  cmd.commit      = 1'b1;
                  running_in      = hit_id;
                  load_out        = 1'b1;
                  rsp_status_in   = RSP_OK;
                  rsp_id_in       = ID_OUT_W'(hit_id);
                  rsp_switched_in = 1'b1;
                  // the main context never got a start address
                  rsp_addr_in     = (hit_id == '0) ? '0 : hit_addr;
                  state_in        = ST_IDLE;
               end else if (steps_ff <= CNT_W'(1)) begin
                  load_out        = 1'b1;
                  rsp_status_in   = RSP_NO_SWITCH;
                  rsp_id_in       = '0;
                  rsp_switched_in = 1'b0;
                  rsp_addr_in     = '0;
                  state_in        = ST_IDLE;
               end else begin
                  cmd.seek_step = 1'b1;
                  steps_in      = steps_ff - CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= CNT_W'(1);
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff        <= steps_in;
      addr_ff         <= addr_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_switched_ff <= rsp_switched_in;
      rsp_addr_ff     <= rsp_addr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_thread_id    = rsp_id_ff;
   assign rsp_switched     = rsp_switched_ff;
   assign rsp_next_address = rsp_addr_ff;

endmodule

// ===== design/round_robin_thread_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler_core
// Thread table with cooperative round-robin switching over a ring of slot cells.
// ----------------------------------------------------------------------------
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  request | req_valid/ready, opcode, start_address  | in
//  result  | rsp_valid/ready, status, thread_id,     | out
//          | switched, next_address                  |
//
// Spawn: the result is registered from the spawn state once the result register is free.
// Yield: the search token is placed on the slot after the running one and probes
// 1 .. THREAD_SLOTS-1 slots; it moves one cell per cycle, while the result register is
// free, around the ring of occupied slots.
// One item in flight; a new item is taken once the previous one is finished.
// Reset has no clearing pass: start addresses are not cleared.
// A result left waiting holds the sequencer in its working state until taken.
`include "round_robin_thread_scheduler_core_macros.svh"
module round_robin_thread_scheduler_core
   import rrts_pkg::*;
#(
   parameter int unsigned THREAD_SLOTS = THREAD_SLOTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [ADDR_W-1:0]   req_start_address,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [ID_OUT_W-1:0] rsp_thread_id,
   output logic                rsp_switched,
   output logic [ADDR_W-1:0]   rsp_next_address
);

   localparam int unsigned ID_W = $clog2(THREAD_SLOTS);

   cell_cmd_type      cmd;
   logic [ID_W-1:0]   spawn_id;
   logic [ID_W-1:0]   start_id;
   logic [ID_W-1:0]   last_id;
   logic [ADDR_W-1:0] spawn_addr;
   logic              any_hit;
   logic [ID_W-1:0]   hit_id;
   logic [ADDR_W-1:0] hit_addr;
   logic              wrap_any;

   logic [THREAD_SLOTS-1:0] token_prev_vec;
   logic [THREAD_SLOTS-1:0] token_next_vec;
   logic [THREAD_SLOTS-1:0] token_wrap_vec;
   logic [THREAD_SLOTS-1:0] token_vec;
   logic [THREAD_SLOTS-1:0] hit_vec;
   logic [THREAD_SLOTS-1:0] running_vec;
   logic [ADDR_W-1:0]       addr_vec [THREAD_SLOTS];

   rrts_ctrl #(
      .THREAD_SLOTS(THREAD_SLOTS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_start_address(req_start_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_thread_id    (rsp_thread_id),
      .rsp_switched     (rsp_switched),
      .rsp_next_address (rsp_next_address),
      .cmd              (cmd),
      .spawn_id         (spawn_id),
      .start_id         (start_id),
      .last_id          (last_id),
      .spawn_addr       (spawn_addr),
      .any_hit          (any_hit),
      .hit_id           (hit_id),
      .hit_addr         (hit_addr)
   );

   // the last occupied slot hands the token back to slot 0
   assign wrap_any = |token_wrap_vec;

   for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign token_prev_vec[g] = wrap_any;
      end else begin : g_body
         assign token_prev_vec[g] = token_next_vec[g-1];
      end

      rrts_cell #(
         .THREAD_SLOTS(THREAD_SLOTS),
         .CELL_INDEX  (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .spawn_id  (spawn_id),
         .start_id  (start_id),
         .last_id   (last_id),
         .spawn_addr(spawn_addr),
         .token_prev(token_prev_vec[g]),
         .token_next(token_next_vec[g]),
         .token_wrap(token_wrap_vec[g]),
         .hit       (hit_vec[g]),
         .running   (running_vec[g]),
         .entry_addr(addr_vec[g])
      );
   end

   // at most one cell holds the token, so OR-ing selects it
   always_comb begin
      hit_id   = '0;
      hit_addr = '0;
      for (int i = 0; i < THREAD_SLOTS; i++) begin
         if (hit_vec[i]) begin
            hit_id   = hit_id | ID_W'(i);
            hit_addr = hit_addr | addr_vec[i];
         end
      end
   end

   assign any_hit   = |hit_vec;
   assign token_vec = token_next_vec | token_wrap_vec;

   `RRTS_ASSERT_NOW(a_one_running, clock, reset, 1'b1, $onehot(running_vec), "not one running")
   `RRTS_ASSERT_NOW(a_token_single, clock, reset, 1'b1, $onehot0(token_vec), "token split")
   `RRTS_ASSERT_NOW(a_switch_ok, clock, reset, rsp_valid && rsp_switched,
                    rsp_status == RSP_OK, "switch reported with bad status")
   `RRTS_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && req_ready,
                     !req_ready, "item taken while busy")

endmodule

// ===== tb/sv/tb_round_robin_thread_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_thread_scheduler_core
// Self-checking bench: drives spawn and yield requests, keeps its own thread
// table in step with every accepted item and compares each response with it.
// ----------------------------------------------------------------------------
module tb_round_robin_thread_scheduler_core;
   import rrts_pkg::*;

   localparam int unsigned SLOTS       = THREAD_SLOTS_DEF;
   localparam int unsigned LONG_STALL  = 300;
   localparam int unsigned SETTLE_CYC  = 40;

   typedef struct packed {
      logic [STAT_W-1:0]   status;
      logic [ID_OUT_W-1:0] id;
      logic                sw;
      logic [ADDR_W-1:0]   next_addr;
   } sched_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_opcode;
   logic [ADDR_W-1:0]   req_start_address;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STAT_W-1:0]   rsp_status;
   logic [ID_OUT_W-1:0] rsp_thread_id;
   logic                rsp_switched;
   logic [ADDR_W-1:0]   rsp_next_address;

   // shadow thread table
   logic [4:0]          tbl_total;
   logic [3:0]          tbl_running;
   thread_state_type    tbl_state [SLOTS];
   logic [ADDR_W-1:0]   tbl_addr  [SLOTS];

   sched_result_type    pending_results [$];

   bit                  idle_on = 1'b1;
   int unsigned         stall_cycles_req = 0;
   int unsigned         fail_count = 0;
   int unsigned         items_taken = 0;
   int unsigned         spawns_ok = 0;
   int unsigned         spawns_refused = 0;
   int unsigned         switches = 0;
   int unsigned         no_switches = 0;

   round_robin_thread_scheduler_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_start_address(req_start_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_thread_id    (rsp_thread_id),
      .rsp_switched     (rsp_switched),
      .rsp_next_address (rsp_next_address)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // advance the shadow table by one item and return the response it implies
   function automatic sched_result_type schedule_step(input logic opc,
                                                      input logic [ADDR_W-1:0] addr);
      sched_result_type r;
      int unsigned      k;
      int unsigned      idx;
      bit               found;
      r = '{status: RSP_NO_SWITCH, id: '0, sw: 1'b0, next_addr: '0};
      found = 1'b0;
      if (opc == OPC_SPAWN) begin
         if (tbl_total >= SLOTS || addr == '0) begin
            r.status = RSP_REFUSED;
         end else begin
            tbl_state[tbl_total] = TS_READY;
            tbl_addr[tbl_total]  = addr;
            r.status = RSP_OK;
            r.id     = tbl_total[3:0];
            tbl_total = tbl_total + 5'd1;
         end
      end else if (tbl_total > 1 && tbl_running < tbl_total) begin
         for (k = 1; k < tbl_total && !found; k++) begin
            idx = (tbl_running + k) % tbl_total;
            if (tbl_state[idx] == TS_READY) begin
               found = 1'b1;
               tbl_state[tbl_running] = TS_READY;
               tbl_state[idx]         = TS_RUNNING;
               tbl_running            = idx[3:0];
               r.status    = RSP_OK;
               r.id        = idx[3:0];
               r.sw        = 1'b1;
               r.next_addr = tbl_addr[idx];
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   // responses are popped before the same edge's request is predicted
   always @(posedge clock) begin : result_check
      sched_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected response: expected none, got status %0d id %0d",
                        $time, rsp_status, rsp_thread_id);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status",       want.status,    rsp_status);
               check_field("thread_id",    want.id,        rsp_thread_id);
               check_field("switched",     want.sw,        rsp_switched);
               check_field("next_address", want.next_addr, rsp_next_address);
            end
         end
         if (req_valid && req_ready) begin
            want = schedule_step(req_opcode, req_start_address);
            pending_results.push_back(want);
            items_taken++;
            if (req_opcode == OPC_SPAWN && want.status == RSP_OK) spawns_ok++;
            if (want.status == RSP_REFUSED) spawns_refused++;
            if (want.sw) switches++;
            if (want.status == RSP_NO_SWITCH) no_switches++;
         end
      end
   end

   // response side: short random holds, or one long hold on request
   initial begin : rsp_side
      int unsigned n;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_cycles_req != 0) begin
            n = stall_cycles_req;
            stall_cycles_req = 0;
            rsp_ready = 1'b0;
            repeat (n - 1) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the handshake
   task automatic send_item(input logic opc, input logic [ADDR_W-1:0] addr);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_opcode        = opc;
      req_start_address = addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic send_random(input int unsigned count);
      int unsigned      i;
      logic [ADDR_W-1:0] a;
      for (i = 0; i < count; i++) begin
         a = $urandom;
         if ($urandom_range(0, 9) < 7) begin
            send_item(OPC_YIELD, a);
         end else begin
            if ($urandom_range(0, 3) == 0) a = '0;
            send_item(OPC_SPAWN, a);
         end
      end
   endtask

   task automatic test_lone_thread();
      send_item(OPC_YIELD, 32'hFFFF_FFFF);
      send_item(OPC_SPAWN, 32'h0000_0000);
      send_item(OPC_YIELD, 32'h0000_0000);
   endtask

   task automatic test_switch_and_resume();
      send_item(OPC_SPAWN, 32'hFFFF_FFFF);
      send_item(OPC_YIELD, 32'h0000_0000);
      // back to main: it never had a start address
      send_item(OPC_YIELD, 32'h1234_5678);
      send_item(OPC_SPAWN, 32'h0000_0001);
      send_item(OPC_SPAWN, 32'h0000_0000);
   endtask

   task automatic test_fill_table();
      send_item(OPC_SPAWN, 32'h8000_0000);
      while (tbl_total < SLOTS) begin
         send_item(OPC_SPAWN, $urandom | 32'h1);
         if ($urandom_range(0, 2) == 0) send_item(OPC_YIELD, $urandom);
      end
      send_item(OPC_SPAWN, 32'h7FFF_FFFF);
      send_item(OPC_SPAWN, 32'h0000_0000);
      send_item(OPC_YIELD, 32'h0);
   endtask

   task automatic test_random_mix();
      send_random(1200);
   endtask

   task automatic test_backpressure();
      wait_drained();
      stall_cycles_req = LONG_STALL;
      send_random(12);
      // sender pauses until every response is back
      wait_drained();
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      send_random(470);
   endtask

   initial begin
      int unsigned i;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OPC_SPAWN;
      req_start_address = '0;
      tbl_total   = 5'd1;
      tbl_running = 4'd0;
      for (i = 0; i < SLOTS; i++) begin
         tbl_state[i] = TS_ZOMBIE;
         tbl_addr[i]  = '0;
      end
      tbl_state[0] = TS_RUNNING;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_lone_thread();
      test_switch_and_resume();
      test_fill_table();
      test_random_mix();
      test_backpressure();
      test_back_to_back();

      wait_drained();
      repeat (SETTLE_CYC) @(posedge clock);
      $display("Ran %0d items: %0d spawns taken, %0d refused, %0d switches, %0d no-switch.",
               items_taken, spawns_ok, spawns_refused, switches, no_switches);
      $display("Lone thread, null address, full table, main resumed, %0d-cycle hold done.",
               LONG_STALL);
      if (fail_count == 0) begin
         $display("tb_round_robin_thread_scheduler_core OK");
      end else begin
         $display("tb_round_robin_thread_scheduler_core NOT OK");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timed out with %0d responses outstanding", pending_results.size());
      $display("tb_round_robin_thread_scheduler_core NOT OK");
      $finish;
   end

endmodule

// ===== round_robin_thread_scheduler_core.f =====
+incdir+design
design/rrts_pkg.sv
design/rrts_cell.sv
design/rrts_ctrl.sv
design/round_robin_thread_scheduler_core.sv
tb/sv/tb_round_robin_thread_scheduler_core.sv
